// ===== hw/rtl/sliding_piece_attack_bitboard_macros.svh =====
// Assertion macros used by the checker of the sliding attack block.
// Depends on nothing; included by the checker file.
`ifndef SLIDING_PIECE_ATTACK_BITBOARD_MACROS_SVH
`define SLIDING_PIECE_ATTACK_BITBOARD_MACROS_SVH

// An implication checked at every clock edge outside reset.
`define SPAB_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spab assertion failed");

// A next-cycle implication checked at every clock edge outside reset.
`define SPAB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spab assertion failed");

// A next-cycle implication that is also checked while reset is high.
`define SPAB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("spab assertion failed");

`endif

// ===== hw/rtl/spab_pkg.sv =====
// Package of the sliding attack block: board constants, ray steps and
// the token type that travels down the chain of cells. No dependencies.
package spab_pkg;

  localparam int BB_W      = 64;
  localparam int SQ_W      = 6;
  localparam int COORD_W   = 3;
  localparam int RAY_CNT   = 4;
  localparam int CHAIN_LEN = 7;

  typedef logic [BB_W-1:0]    bb_t;
  typedef logic [COORD_W:0]   coord_ext_t;

  typedef enum logic {
    FUNC_ROOK   = 1'b0,
    FUNC_BISHOP = 1'b1
  } func_t;

  // Per-ray walk state: position of the last visited square, whether it
  // was on the board, and whether no blocker has been met yet.
  typedef struct packed {
    logic               on;
    logic               live;
    logic [COORD_W-1:0] rank;
    logic [COORD_W-1:0] file;
  } ray_t;

  typedef struct packed {
    func_t              func;
    bb_t                occupancy;
    bb_t                attacks;
    bb_t                relevant_mask;
    ray_t [RAY_CNT-1:0] rays;
  } token_t;

  typedef struct packed {
    coord_ext_t dr;
    coord_ext_t df;
  } step_t;

  // Rank and file step of each ray, as 4-bit two's complement values.
  function automatic step_t ray_step(input func_t func, input logic [1:0] idx);
    step_t s;
    s = '{dr: '0, df: '0};
    case ({func, idx})
      {FUNC_ROOK,   2'd0}: s = '{dr: 4'b0001, df: 4'b0000};
      {FUNC_ROOK,   2'd1}: s = '{dr: 4'b1111, df: 4'b0000};
      {FUNC_ROOK,   2'd2}: s = '{dr: 4'b0000, df: 4'b0001};
      {FUNC_ROOK,   2'd3}: s = '{dr: 4'b0000, df: 4'b1111};
      {FUNC_BISHOP, 2'd0}: s = '{dr: 4'b0001, df: 4'b0001};
      {FUNC_BISHOP, 2'd1}: s = '{dr: 4'b0001, df: 4'b1111};
      {FUNC_BISHOP, 2'd2}: s = '{dr: 4'b1111, df: 4'b0001};
      {FUNC_BISHOP, 2'd3}: s = '{dr: 4'b1111, df: 4'b1111};
      default:             s = '{dr: '0, df: '0};
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/spab_if.sv =====
// Valid/ready channel interfaces for the sliding attack block.
// Depends on nothing.
interface spab_req_if;
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [5:0]            square;
  logic [63:0]           occupancy;

  modport source (output valid, func, square, occupancy, input ready);
  modport sink   (input valid, func, square, occupancy, output ready);
endinterface

interface spab_rsp_if;
  logic                  valid;
  logic                  ready;
  logic [63:0]           attacks;
  logic [63:0]           relevant_mask;

  modport source (output valid, attacks, relevant_mask, input ready);
  modport sink   (input valid, attacks, relevant_mask, output ready);
endinterface

// ===== hw/rtl/spab_cell.sv =====
// One cell of the ray chain: advances all four rays by one square and
// registers the token for the next cell. Depends on spab_pkg.
module spab_cell
  import spab_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   up_valid,
  output logic   up_ready,
  input  token_t up_tok,
  output logic   dn_valid,
  input  logic   dn_ready,
  output token_t dn_tok
);

  logic   vld;
  token_t tok;
  token_t tok_next;

  always_comb begin
    step_t      s;
    coord_ext_t nr;
    coord_ext_t nf;
    coord_ext_t nnr;
    coord_ext_t nnf;
    logic       nb;
    bb_t        sq_bit;
    tok_next = up_tok;
    for (int k = 0; k < RAY_CNT; k++) begin
      s   = ray_step(up_tok.func, 2'(k));
      nr  = {1'b0, up_tok.rays[k].rank} + s.dr;
      nf  = {1'b0, up_tok.rays[k].file} + s.df;
      nnr = nr + s.dr;
      nnf = nf + s.df;
      // The top bit flags a step off either side of the board.
      nb  = up_tok.rays[k].on && !nr[COORD_W] && !nf[COORD_W];
      sq_bit = bb_t'(1) << {nr[COORD_W-1:0], nf[COORD_W-1:0]};
      if (nb) begin
        if (!nnr[COORD_W] && !nnf[COORD_W]) begin
          tok_next.relevant_mask = tok_next.relevant_mask | sq_bit;
        end
        if (up_tok.rays[k].live) begin
          tok_next.attacks = tok_next.attacks | sq_bit;
        end
      end
      tok_next.rays[k].on   = nb;
      tok_next.rays[k].live = up_tok.rays[k].live && nb && ((up_tok.occupancy & sq_bit) == '0);
      tok_next.rays[k].rank = nr[COORD_W-1:0];
      tok_next.rays[k].file = nf[COORD_W-1:0];
    end
  end

  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok <= tok_next;
    end
  end

  assign dn_valid = vld;
  assign dn_tok   = tok;

endmodule

// ===== hw/rtl/sliding_piece_attack_bitboard.sv =====
// Channel   Dir  Payload                           Handshake
// req       in   func, square, occupancy           valid/ready
// rsp       out  attacks, relevant_mask            valid/ready
//
// The request passes the chain of 7 cells, one cell per square of ray length.
// A new request is taken every cycle unless the full chain stalls on the response.
// Each cell takes a new transaction when it is empty or its successor takes its own,
// so empty cells fill up while the response stalls.
// Reset (synchronous, active high) empties all cells; the token registers are not reset.
// Depends on spab_pkg, spab_if and spab_cell.
module sliding_piece_attack_bitboard
  import spab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  spab_req_if.sink    req,
  spab_rsp_if.source  rsp
);

  logic   [CHAIN_LEN:0] vld_chain;
  logic   [CHAIN_LEN:0] rdy_chain;
  token_t               tok_chain [CHAIN_LEN+1];
  token_t               head_tok;

  // The origin square seeds every ray; its occupancy bit is never looked at.
  always_comb begin
    head_tok.func          = func_t'(req.func);
    head_tok.occupancy     = req.occupancy;
    head_tok.attacks       = '0;
    head_tok.relevant_mask = '0;
    for (int k = 0; k < RAY_CNT; k++) begin
      head_tok.rays[k].on   = 1'b1;
      head_tok.rays[k].live = 1'b1;
      head_tok.rays[k].rank = req.square[SQ_W-1:COORD_W];
      head_tok.rays[k].file = req.square[COORD_W-1:0];
    end
  end

  assign tok_chain[0] = head_tok;
  assign vld_chain[0] = req.valid;
  assign req.ready    = rdy_chain[0];

  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
    spab_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (vld_chain[i]),
      .up_ready (rdy_chain[i]),
      .up_tok   (tok_chain[i]),
      .dn_valid (vld_chain[i+1]),
      .dn_ready (rdy_chain[i+1]),
      .dn_tok   (tok_chain[i+1])
    );
  end

  assign rdy_chain[CHAIN_LEN] = rsp.ready;
  assign rsp.valid            = vld_chain[CHAIN_LEN];
  assign rsp.attacks          = tok_chain[CHAIN_LEN].attacks;
  assign rsp.relevant_mask    = tok_chain[CHAIN_LEN].relevant_mask;

endmodule

// ===== hw/rtl/spab_checker.sv =====
// Port-level checker for the sliding attack block and its bind.
// Depends on the assertion macros header and the top level.
`include "sliding_piece_attack_bitboard_macros.svh"

module spab_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [63:0] rsp_attacks,
  input logic [63:0] rsp_relevant_mask
);

  // A stalled response stays valid and keeps its attacks.
  `SPAB_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_attacks))

  // No response is presented right after reset.
  `SPAB_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !rsp_valid)

  // Every square has a neighbor on each piece's rays, so attacks are never empty.
  `SPAB_ASSERT_IMPL(a_attacks_nonzero, clk, rst, rsp_valid, rsp_attacks != 64'd0)

  // A rook sees at most 14 squares and keeps at most 12 relevant ones.
  `SPAB_ASSERT_IMPL(a_counts, clk, rst, rsp_valid, ($countones(rsp_attacks) <= 14) && ($countones(rsp_relevant_mask) <= 12))

endmodule

bind sliding_piece_attack_bitboard spab_checker u_spab_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_attacks       (rsp.attacks),
  .rsp_relevant_mask (rsp.relevant_mask)
);
